@@ rtl/tbdm_pkg.sv @@
// Shared types, constants and helpers for the ternary bracket depth mask.
// Holds the per-trit scan word that travels down the pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbdm_pkg;

  localparam int KEY_W      = 23;
  localparam int COUNT_W    = 4;
  localparam int DEPTH_IN_W = 4;
  localparam int MASK_W     = 8;

  localparam int MAX_DIGITS = 14;
  localparam int MASK_BITS  = 8;

  // 3^15 exceeds 2^23, so fifteen trits cover every key
  localparam int KEY_TRITS = 15;
  localparam int POW_W     = KEY_W + 2;

  // start depth 0..15 moved by at most fourteen steps: -14..29
  localparam int DEPTH_W = 6;

  localparam int RANK_CAP = (MASK_BITS < MASK_W) ? MASK_BITS : MASK_W;
  localparam int RANK_W   = $clog2(RANK_CAP + 1);

  typedef enum logic [1:0] {
    TRIT_NONE  = 2'd0,
    TRIT_CLOSE = 2'd1,
    TRIT_OPEN  = 2'd2
  } trit_t;

  typedef struct packed {
    logic [KEY_W-1:0]          rest;
    logic [COUNT_W-1:0]        count;
    logic signed [DEPTH_W-1:0] depth;
    logic                      halted;
    logic [RANK_W-1:0]         rank;
    logic [MASK_W-1:0]         mask;
  } scan_word_t;

  function automatic logic [POW_W-1:0] pow3(input int unsigned n);
    logic [POW_W-1:0] p;
    p = POW_W'(1);
    for (int unsigned j = 0; j < n; j++) begin
      p = POW_W'(p * 3);
    end
    return p;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] c);
    if (int'(c) > MAX_DIGITS) begin
      return COUNT_W'(MAX_DIGITS);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tbdm_digit.sv @@
// One pipeline stage: peels off a single trit (most significant remaining)
// and applies it to the bracket scan. Depends on tbdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbdm_digit
  import tbdm_pkg::*;
#(
  parameter int DIGIT = 0
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  var  scan_word_t in_word,
  output logic            out_valid,
  input  wire logic       out_stall,
  output scan_word_t      out_word
);

  logic [POW_W-1:0] step_one;
  logic [POW_W-1:0] step_two;
  logic [POW_W-1:0] rest_wide;
  trit_t            trit;
  logic             scan_en;
  logic             advance;
  scan_word_t       word_next;

  // take a new word whenever the register is empty or drains this cycle
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  always_comb begin
    step_one  = pow3(DIGIT);
    step_two  = step_one << 1;
    rest_wide = POW_W'(in_word.rest);

    priority if (rest_wide >= step_two) begin
      trit = TRIT_OPEN;
    end else if (rest_wide >= step_one) begin
      trit = TRIT_CLOSE;
    end else begin
      trit = TRIT_NONE;
    end

    word_next = in_word;
    unique case (trit)
      TRIT_OPEN:  word_next.rest = KEY_W'(rest_wide - step_two);
      TRIT_CLOSE: word_next.rest = KEY_W'(rest_wide - step_one);
      default:    word_next.rest = in_word.rest;
    endcase

    // digits at or above the count are ignored, and nothing moves after a halt
    scan_en = (int'(in_word.count) > DIGIT) && !in_word.halted;

    if (scan_en) begin
      unique case (trit)
        TRIT_CLOSE: begin
          if (in_word.depth == DEPTH_W'(1)) begin
            word_next.halted = 1'b1;
          end else begin
            word_next.depth = in_word.depth - DEPTH_W'(1);
          end
        end
        TRIT_OPEN: begin
          if (in_word.rank < RANK_W'(RANK_CAP)) begin
            if (in_word.depth == DEPTH_W'(1)) begin
              word_next.mask = in_word.mask | (MASK_W'(1) << in_word.rank);
            end
            word_next.rank = in_word.rank + RANK_W'(1);
          end
          word_next.depth = in_word.depth + DEPTH_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_word <= word_next;
    end
  end

`ifndef SYNTH
  a_rest_below_pow: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (POW_W'(out_word.rest) < pow3(DIGIT)))
    else $error("remainder not below 3^DIGIT after stage");

  a_halt_freezes_mask: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_word.halted) |=>
      (out_valid && out_word.halted && out_word.mask == $past(in_word.mask)))
    else $error("mask changed after the scan halted");

  a_rank_capped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.rank <= RANK_W'(RANK_CAP)))
    else $error("open rank ran past its cap");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("stage stalled while it could drain");
`endif

endmodule

`default_nettype wire

@@ rtl/ternary_bracket_depth_mask.sv @@
// Top level of the ternary bracket depth mask: a chain of per-trit stages.
// Depends on tbdm_pkg and tbdm_digit.
//
// Usage:
//   Input channel (in_valid / in_stall) carries a word of key_value,
//   digit_count and start_depth. Output channel (out_valid / out_stall)
//   carries rank_mask, one result word per input word, in order.
//   The key is scanned most significant trit first, one trit per stage, over
//   fifteen register stages (enough trits to cover a 23-bit key).
//   Throughput: one word per cycle while out_stall stays low.
//   Each stage holds its word while the next one is full and stalled, and
//   empty stages keep filling, so bubbles close up under a stalled output.
//   in_stall rises only once every stage holds a word and out_stall is high.
//   Reset (rst, synchronous) clears every stage's valid bit; words in flight
//   are dropped. No configuration, no state beyond the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module ternary_bracket_depth_mask
  import tbdm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [KEY_W-1:0]      key_value,
  input  wire logic [COUNT_W-1:0]    digit_count,
  input  wire logic [DEPTH_IN_W-1:0] start_depth,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [MASK_W-1:0]          rank_mask
);

  logic [KEY_TRITS:0] stage_valid;
  logic [KEY_TRITS:0] stage_stall;
  scan_word_t         stage_word [KEY_TRITS+1];

  always_comb begin
    stage_word[0].rest   = key_value;
    stage_word[0].count  = sat_count(digit_count);
    stage_word[0].depth  = DEPTH_W'(start_depth);
    stage_word[0].halted = 1'b0;
    stage_word[0].rank   = '0;
    stage_word[0].mask   = '0;
  end

  assign stage_valid[0] = in_valid;
  assign in_stall       = stage_stall[0];

  for (genvar s = 0; s < KEY_TRITS; s++) begin : g_stage
    tbdm_digit #(
      .DIGIT(KEY_TRITS - 1 - s)
    ) u_digit (
      .clk      (clk),
      .rst      (rst),
      .in_valid (stage_valid[s]),
      .in_stall (stage_stall[s]),
      .in_word  (stage_word[s]),
      .out_valid(stage_valid[s+1]),
      .out_stall(stage_stall[s+1]),
      .out_word (stage_word[s+1])
    );
  end

  assign stage_stall[KEY_TRITS] = out_stall;
  assign out_valid              = stage_valid[KEY_TRITS];
  assign rank_mask              = stage_word[KEY_TRITS].mask;

endmodule

`default_nettype wire
